>>> hdl/ac3shp_pkg.sv
// ----------------------------------------------------------------------------
// AC-3 sync header parser package
// Shared types, header codes and the A/52 frame size table.
// ----------------------------------------------------------------------------
package ac3shp_pkg;

    // Width of the packed result bus.
    localparam int TDATA_W = 112;

    // Sync word, split into its two stream bytes.
    localparam logic [7:0] SYNC_BYTE_HI = 8'h0B;
    localparam logic [7:0] SYNC_BYTE_LO = 8'h77;

    // Header bytes are numbered from the first byte after the sync word.
    localparam logic [2:0] HDR_LAST_IDX = 3'd5;

    // Distance in bytes from the first sync byte to the last header byte.
    localparam int HDR_SPAN = 7;

    // Bytes of a sync frame that the sync word and header already consumed.
    localparam logic [11:0] HDR_FRAME_BYTES = 12'd8;

    // Sample rate codes.
    localparam logic [1:0] FSCOD_48K      = 2'd0;
    localparam logic [1:0] FSCOD_44K1     = 2'd1;
    localparam logic [1:0] FSCOD_32K      = 2'd2;
    localparam logic [1:0] FSCOD_RESERVED = 2'd3;

    // Highest frame size code in the table.
    localparam logic [5:0] FRMSIZECOD_MAX = 6'd37;

    // Audio coding modes.
    localparam logic [2:0] ACMOD_DUAL_MONO = 3'd0;
    localparam logic [2:0] ACMOD_MONO      = 3'd1;
    localparam logic [2:0] ACMOD_STEREO    = 3'd2;
    localparam logic [2:0] ACMOD_3F        = 3'd3;
    localparam logic [2:0] ACMOD_2F1R      = 3'd4;
    localparam logic [2:0] ACMOD_3F1R      = 3'd5;
    localparam logic [2:0] ACMOD_2F2R      = 3'd6;
    localparam logic [2:0] ACMOD_3F2R      = 3'd7;

    typedef enum logic [1:0] {
        PH_START,
        PH_HUNT,
        PH_COLLECT,
        PH_FRAME
    } phase_t;

    // A captured header on its way to the decode stage.
    typedef struct packed {
        logic [31:0]     offset;
        logic [5:0][7:0] hb;
        logic [10:0]     words;
        logic            err;
    } hdr_t;

    typedef struct packed {
        logic [31:0] header_offset;
        logic [15:0] crc_word;
        logic [1:0]  sample_rate_code;
        logic [5:0]  frame_size_code;
        logic [10:0] frame_words;
        logic [4:0]  stream_id;
        logic [2:0]  service_mode;
        logic [2:0]  channel_mode;
        logic        lfe_on;
        logic [31:0] frame_number;
        logic        header_error;
    } result_t;

    // Frame length in words for each bit rate step; odd size codes at 44.1 kHz
    // add one word.
    localparam logic [10:0] WORDS_48K [0:18] = '{
        11'd64,  11'd80,  11'd96,  11'd112, 11'd128, 11'd160, 11'd192,
        11'd224, 11'd256, 11'd320, 11'd384, 11'd448, 11'd512, 11'd640,
        11'd768, 11'd896, 11'd1024, 11'd1152, 11'd1280
    };
    localparam logic [10:0] WORDS_44K1 [0:18] = '{
        11'd69,  11'd87,  11'd104, 11'd121, 11'd139, 11'd174, 11'd208,
        11'd243, 11'd278, 11'd348, 11'd417, 11'd487, 11'd557, 11'd696,
        11'd835, 11'd975, 11'd1114, 11'd1253, 11'd1393
    };
    localparam logic [10:0] WORDS_32K [0:18] = '{
        11'd96,  11'd120, 11'd144, 11'd168, 11'd192, 11'd240, 11'd288,
        11'd336, 11'd384, 11'd480, 11'd576, 11'd672, 11'd768, 11'd960,
        11'd1152, 11'd1344, 11'd1536, 11'd1728, 11'd1920
    };

    function automatic logic hdr_bad_f(input logic [1:0] fscod, input logic [5:0] fsize);
        return (fscod == FSCOD_RESERVED) || (fsize > FRMSIZECOD_MAX);
    endfunction

    // Returns zero for a reserved rate or a size code beyond the table.
    function automatic logic [10:0] frame_words_f(input logic [1:0] fscod,
                                                  input logic [5:0] fsize);
        logic [4:0]  rate_idx;
        logic [10:0] words;
        rate_idx = fsize[5:1];
        words    = '0;
        if (!hdr_bad_f(fscod, fsize)) begin
            unique case (fscod)
                FSCOD_48K:  words = WORDS_48K[rate_idx];
                FSCOD_44K1: words = WORDS_44K1[rate_idx] + {10'd0, fsize[0]};
                FSCOD_32K:  words = WORDS_32K[rate_idx];
                default:    words = '0;
            endcase
        end
        return words;
    endfunction

endpackage

>>> hdl/ac3shp_framer.sv
// ----------------------------------------------------------------------------
// AC-3 sync header parser framer
// Byte-level state machine: start skip, sync hunt, header capture, frame skip.
// ----------------------------------------------------------------------------
module ac3shp_framer #(
    parameter int POSITION_BITS = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [31:0]       start_skip,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  logic [7:0]        data_byte,
    output logic              hdr_valid,
    input  logic              hdr_ready,
    output ac3shp_pkg::hdr_t  hdr
);
    import ac3shp_pkg::*;

    localparam logic [POSITION_BITS-1:0] SPAN = POSITION_BITS'(HDR_SPAN);

    phase_t                   phase_reg, phase_next;
    logic [31:0]              cnt_reg, cnt_next;
    logic [7:0]               prev_reg, prev_next;
    logic                     have_prev_reg, have_prev_next;
    logic [7:0]               hb_reg [0:4];
    logic [POSITION_BITS-1:0] pos_reg;
    logic                     hdr_valid_reg, hdr_valid_next;
    hdr_t                     hdr_reg, hdr_next;

    logic        accept;
    logic        skip_more;
    logic        sync_hit;
    logic        hdr_done;
    logic        hdr_err;
    logic [10:0] words_now;
    logic [31:0] cnt_dec;
    logic        frame_done;
    logic        emit;

    assign byte_ready = !hdr_valid_reg || hdr_ready;
    assign accept     = byte_valid && byte_ready;

    assign skip_more  = cnt_reg < start_skip;
    assign sync_hit   = have_prev_reg && (prev_reg == SYNC_BYTE_HI)
                        && (data_byte == SYNC_BYTE_LO);
    assign hdr_done   = cnt_reg[2:0] == HDR_LAST_IDX;
    assign hdr_err    = hdr_bad_f(hb_reg[2][7:6], hb_reg[2][5:0]);
    assign words_now  = frame_words_f(hb_reg[2][7:6], hb_reg[2][5:0]);
    assign cnt_dec    = (cnt_reg != 32'd0) ? cnt_reg - 32'd1 : 32'd0;
    assign frame_done = cnt_dec == 32'd0;

    // Next state.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_START:   if (!skip_more) phase_next = PH_HUNT;
                PH_HUNT:    if (sync_hit) phase_next = PH_COLLECT;
                PH_COLLECT: if (hdr_done) phase_next = hdr_err ? PH_HUNT : PH_FRAME;
                PH_FRAME:   if (frame_done) phase_next = PH_HUNT;
                default:    phase_next = PH_START;
            endcase
        end
    end

    // Counter and hunt history.
    always_comb begin
        cnt_next       = cnt_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        if (accept) begin
            unique case (phase_reg)
                PH_START: begin
                    if (skip_more) begin
                        cnt_next = cnt_reg + 32'd1;
                    end else begin
                        cnt_next       = '0;
                        prev_next      = data_byte;
                        have_prev_next = 1'b1;
                    end
                end
                PH_HUNT: begin
                    if (sync_hit) begin
                        cnt_next       = '0;
                        have_prev_next = 1'b0;
                    end else begin
                        prev_next      = data_byte;
                        have_prev_next = 1'b1;
                    end
                end
                PH_COLLECT: begin
                    cnt_next = cnt_reg + 32'd1;
                    if (hdr_done) begin
                        if (hdr_err) begin
                            cnt_next       = '0;
                            have_prev_next = 1'b0;
                        end else begin
                            cnt_next = 32'({words_now, 1'b0} - HDR_FRAME_BYTES);
                        end
                    end
                end
                PH_FRAME: begin
                    cnt_next = cnt_dec;
                    if (frame_done) have_prev_next = 1'b0;
                end
                default: cnt_next = '0;
            endcase
        end
    end

    // Outputs toward the decode stage.
    always_comb begin
        emit           = accept && (phase_reg == PH_COLLECT) && hdr_done;
        hdr_valid_next = hdr_valid_reg;
        hdr_next       = hdr_reg;
        if (emit) begin
            hdr_valid_next = 1'b1;
            hdr_next.offset = 32'(pos_reg - SPAN);
            hdr_next.hb     = {data_byte, hb_reg[4], hb_reg[3], hb_reg[2],
                               hb_reg[1], hb_reg[0]};
            hdr_next.words  = words_now;
            hdr_next.err    = hdr_err;
        end else if (hdr_ready) begin
            hdr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            cnt_reg       <= '0;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            pos_reg       <= '0;
            hdr_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
            hdr_valid_reg <= hdr_valid_next;
            if (accept) pos_reg <= pos_reg + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg <= hdr_next;
        if (accept && (phase_reg == PH_COLLECT) && (cnt_reg[2:0] < HDR_LAST_IDX)) begin
            hb_reg[cnt_reg[2:0]] <= data_byte;
        end
    end

    assign hdr_valid = hdr_valid_reg;
    assign hdr       = hdr_reg;

endmodule

>>> hdl/ac3shp_decode.sv
// ----------------------------------------------------------------------------
// AC-3 sync header parser decode stage
// Splits a captured header into its fields and holds the result register.
// ----------------------------------------------------------------------------
module ac3shp_decode (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                hdr_valid,
    output logic                hdr_ready,
    input  ac3shp_pkg::hdr_t    hdr,
    output logic                res_valid,
    input  logic                res_ready,
    output ac3shp_pkg::result_t res
);
    import ac3shp_pkg::*;

    logic        res_valid_reg;
    result_t     res_reg, res_next;
    logic [31:0] frames_reg;
    logic        load;
    logic [2:0]  acmod;
    logic        lfe;

    assign hdr_ready = !res_valid_reg || res_ready;
    assign load      = hdr_valid && hdr_ready;
    assign acmod     = hdr.hb[4][7:5];

    // The LFE flag sits after the optional mix level fields of the mode.
    always_comb begin
        unique case (acmod) inside
            ACMOD_DUAL_MONO, ACMOD_MONO: lfe = hdr.hb[4][4];
            ACMOD_3F1R, ACMOD_3F2R:      lfe = hdr.hb[4][0];
            default:                     lfe = hdr.hb[4][2];
        endcase
    end

    always_comb begin
        res_next.header_offset    = hdr.offset;
        res_next.crc_word         = {hdr.hb[0], hdr.hb[1]};
        res_next.sample_rate_code = hdr.hb[2][7:6];
        res_next.frame_size_code  = hdr.hb[2][5:0];
        res_next.frame_words      = hdr.words;
        res_next.stream_id        = hdr.hb[3][7:3];
        res_next.service_mode     = hdr.hb[3][2:0];
        res_next.channel_mode     = acmod;
        res_next.lfe_on           = lfe;
        res_next.frame_number     = frames_reg;
        res_next.header_error     = hdr.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
            frames_reg    <= '0;
        end else begin
            if (load) begin
                res_valid_reg <= 1'b1;
                frames_reg    <= frames_reg + 32'd1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

>>> hdl/ac3_sync_header_parser_top.sv
// ----------------------------------------------------------------------------
// AC-3 sync header parser
// Finds A/52 sync frame headers in a byte stream and reports their fields.
// ----------------------------------------------------------------------------
// Usage: the elementary stream enters one byte per transaction on the s_
// channel. After reset the first start_skip bytes are dropped, then the block
// hunts for the sync word and captures the six header bytes that follow it.
// The transaction that carries the last header byte produces one result on
// the m_ channel; all other input transactions produce nothing. A good header
// makes the block skip the rest of its sync frame; a bad one (reserved sample
// rate or unknown frame size code) is flagged on m_tuser and hunting resumes
// right away.
// The result of a header passes through the capture register and then the
// result register before it appears on the m_ channel. Throughput: one byte
// per cycle while s_tready is high. The result register and the capture
// register form two stages, so a stalled receiver only holds off new bytes
// once both stages hold a header. Reset (aresetn low, synchronous) returns
// to the start skip phase, clears the byte position and frame counter and
// sets start_skip to zero. The user must write the start_skip register with
// cfg_wr_en only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module ac3_sync_header_parser_top #(
    parameter int POSITION_BITS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration: start_skip.
    input  logic                           cfg_wr_en,
    input  logic [31:0]                    cfg_wr_data,
    // Input stream; tdata: data_byte[7:0].
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,
    // Result stream; tdata from bit 0: header_offset[31:0], crc_word[47:32],
    // sample_rate_code[49:48], frame_size_code[55:50], frame_words[66:56],
    // stream_id[71:67], service_mode[74:72], channel_mode[77:75],
    // lfe_on[78], frame_number[110:79], zero pad[111].
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ac3shp_pkg::TDATA_W-1:0] m_tdata,
    // tuser: header_error.
    output logic                           m_tuser
);
    import ac3shp_pkg::*;

    logic [31:0] start_skip_reg;
    logic        hdr_valid;
    logic        hdr_ready;
    hdr_t        hdr;
    result_t     res;

    // The skip count only matters until the hunt begins.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_skip_reg <= '0;
        end else if (cfg_wr_en) begin
            start_skip_reg <= cfg_wr_data;
        end
    end

    ac3shp_framer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_skip (start_skip_reg),
        .byte_valid (s_tvalid),
        .byte_ready (s_tready),
        .data_byte  (s_tdata),
        .hdr_valid  (hdr_valid),
        .hdr_ready  (hdr_ready),
        .hdr        (hdr)
    );

    ac3shp_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .hdr_valid (hdr_valid),
        .hdr_ready (hdr_ready),
        .hdr       (hdr),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {1'b0, res.frame_number, res.lfe_on, res.channel_mode,
                      res.service_mode, res.stream_id, res.frame_words,
                      res.frame_size_code, res.sample_rate_code, res.crc_word,
                      res.header_offset};
    assign m_tuser = res.header_error;

endmodule

>>> hdl/ac3shp_checker.sv
// ----------------------------------------------------------------------------
// AC-3 sync header parser checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module ac3shp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [ac3shp_pkg::TDATA_W-1:0] m_tdata,
    input logic                           m_tuser
);
    import ac3shp_pkg::*;

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result transaction holds its payload.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A flagged header carries no frame length.
    a_err_words: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[66:56] == 11'd0)
        else $error("frame length on a bad header");

    // A good header has a real sample rate and a frame length from the table.
    a_good_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            m_tdata[49:48] != FSCOD_RESERVED && m_tdata[66:56] >= 11'd64
            && m_tdata[55:50] <= FRMSIZECOD_MAX)
        else $error("good header with bad fields");

endmodule

bind ac3_sync_header_parser_top ac3shp_checker u_checker (.*);
